// ===== sv/sntl_pkg.sv =====
// ----------------------------------------------------------------------------
// sntl_pkg
// Types, codes and match rules shared by the SCTP NAT table lookup block.
// ----------------------------------------------------------------------------
package sntl_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int KIND_W          = 3;
	localparam int STATUS_W        = 2;
	localparam int SLOT_W          = 4;
	localparam int ADDR_W          = 32;
	localparam int PORT_W          = 16;
	localparam int VTAG_W          = 32;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FIND       = 3'd1;
	localparam logic [KIND_W-1:0] KIND_GET        = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SPECIAL    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_LOCAL_INIT = 3'd4;
	localparam logic [KIND_W-1:0] KIND_LOCAL      = 3'd5;
	localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd6;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] key_local_addr;
		logic [ADDR_W-1:0] key_global_addr;
		logic [ADDR_W-1:0] key_natted_addr;
		logic [PORT_W-1:0] key_local_port;
		logic [PORT_W-1:0] key_global_port;
		logic [PORT_W-1:0] key_natted_port;
		logic [VTAG_W-1:0] key_local_vtag;
		logic [VTAG_W-1:0] key_global_vtag;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [ADDR_W-1:0]   hit_local_addr;
		logic [ADDR_W-1:0]   hit_global_addr;
		logic [ADDR_W-1:0]   hit_natted_addr;
		logic [PORT_W-1:0]   hit_local_port;
		logic [PORT_W-1:0]   hit_global_port;
		logic [PORT_W-1:0]   hit_natted_port;
		logic [VTAG_W-1:0]   hit_local_vtag;
		logic [VTAG_W-1:0]   hit_global_vtag;
	} rsp_t;

	// one table row
	typedef struct packed {
		logic [ADDR_W-1:0] local_addr;
		logic [ADDR_W-1:0] global_addr;
		logic [ADDR_W-1:0] natted_addr;
		logic [PORT_W-1:0] local_port;
		logic [PORT_W-1:0] global_port;
		logic [PORT_W-1:0] natted_port;
		logic [VTAG_W-1:0] local_vtag;
		logic [VTAG_W-1:0] global_vtag;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request, restart scan
		logic step;      // read next row, advance index
		logic wr_shift;  // write read row one place down
		logic to_shift;  // remove hit: restart index after the hit row
		logic cap_hit;   // load hit row into result
		logic ins;       // append row or report full
		logic miss;      // load miss result
		logic dec;       // entry count minus one
		logic fire;      // present result next cycle
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit;       // row in read stage matches
		logic scan_end;  // no row left in flight
		logic is_rem;    // captured request is a remove
	} sts_t;

	function automatic entry_t req_entry(req_t r);
		entry_t e;
		e.local_addr  = r.key_local_addr;
		e.global_addr = r.key_global_addr;
		e.natted_addr = r.key_natted_addr;
		e.local_port  = r.key_local_port;
		e.global_port = r.key_global_port;
		e.natted_port = r.key_natted_port;
		e.local_vtag  = r.key_local_vtag;
		e.global_vtag = r.key_global_vtag;
		return e;
	endfunction

	function automatic rsp_t make_rsp(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] sl,
			entry_t e);
		rsp_t r;
		r.status          = st;
		r.slot            = sl;
		r.hit_local_addr  = e.local_addr;
		r.hit_global_addr = e.global_addr;
		r.hit_natted_addr = e.natted_addr;
		r.hit_local_port  = e.local_port;
		r.hit_global_port = e.global_port;
		r.hit_natted_port = e.natted_port;
		r.hit_local_vtag  = e.local_vtag;
		r.hit_global_vtag = e.global_vtag;
		return r;
	endfunction

	// per-kind field subset compare; e is the row, k the request keys
	function automatic logic sntl_match(logic [KIND_W-1:0] kind, entry_t e, entry_t k);
		logic m;
		unique case (kind)
			KIND_FIND:
				m = e.local_addr == k.local_addr && e.local_port == k.local_port &&
					e.global_addr == k.global_addr && e.global_port == k.global_port &&
					e.global_vtag == k.global_vtag;
			KIND_GET:
				m = e.global_addr == k.global_addr && e.global_port == k.global_port &&
					e.natted_addr == k.natted_addr && e.natted_port == k.natted_port &&
					e.local_vtag == k.local_vtag;
			KIND_SPECIAL:
				m = e.global_addr == k.global_addr && e.global_port == k.global_port &&
					e.natted_addr == k.natted_addr && e.natted_port == k.natted_port &&
					e.global_vtag == '0;
			KIND_LOCAL_INIT:
				m = e.global_addr == k.global_addr && e.global_port == k.local_port &&
					e.local_port == k.global_port;
			KIND_LOCAL:
				m = e.global_addr == k.global_addr && e.global_port == k.local_port &&
					e.local_port == k.global_port && e.local_vtag == k.local_vtag;
			KIND_REMOVE:
				m = (e.global_addr == k.global_addr && e.global_port == k.global_port &&
					e.local_port == k.local_port && e.local_vtag == k.local_vtag) ||
					(e.local_addr == k.global_addr && e.local_port == k.global_port &&
					e.global_port == k.local_port && e.global_vtag == k.local_vtag);
			default:
				m = 1'b0;
		endcase
		return m;
	endfunction

endpackage

// ===== sv/sntl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sntl_ctrl
// Sequencer for the NAT table: insert, first-hit scan, remove with shift-up.
// ----------------------------------------------------------------------------
module sntl_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sntl_pkg::KIND_W-1:0]   kind,
	input  sntl_pkg::sts_t                sts,
	output sntl_pkg::cmd_t                cmd,
	output logic                          busy
);
	import sntl_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_INS,
		S_SCAN,
		S_SHIFT
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = (kind == KIND_INSERT) ? S_INS : S_SCAN;
				end
			end
			S_INS: begin
				cmd.ins  = 1'b1;
				cmd.fire = 1'b1;
				state_d  = S_IDLE;
			end
			S_SCAN: begin
				cmd.step = 1'b1;
				priority if (sts.hit) begin
					cmd.cap_hit = 1'b1;
					if (sts.is_rem) begin
						cmd.to_shift = 1'b1;
						state_d      = S_SHIFT;
					end else begin
						cmd.fire = 1'b1;
						state_d  = S_IDLE;
					end
				end else if (sts.scan_end) begin
					cmd.miss = 1'b1;
					cmd.fire = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_SHIFT: begin
				cmd.step     = 1'b1;
				cmd.wr_shift = 1'b1;
				if (sts.scan_end) begin
					cmd.dec  = 1'b1;
					cmd.fire = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== sv/sntl_dp.sv =====
// ----------------------------------------------------------------------------
// sntl_dp
// Table memory, request register, scan index with one read stage, result reg.
// ----------------------------------------------------------------------------
module sntl_dp #(
	parameter int TABLE_DEPTH = sntl_pkg::TABLE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sntl_pkg::req_t  req,
	input  sntl_pkg::cmd_t  cmd,
	output sntl_pkg::sts_t  sts,
	output logic            done,
	output sntl_pkg::rsp_t  rsp
);
	import sntl_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	entry_t mem [TABLE_DEPTH];

	req_t          req_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] idx_s1;
	logic          v_s1;
	entry_t        rd_s1;
	rsp_t          rsp_q;
	logic          done_q;

	entry_t        key;
	logic          full;
	logic          more;
	logic          we;
	logic [AW-1:0] wa;
	entry_t        wd;
	logic [CW-1:0] sh_dst;

	assign key    = req_entry(req_q);
	assign full   = (cnt_q == CW'(TABLE_DEPTH));
	assign more   = (idx_q < cnt_q);
	assign sh_dst = idx_s1 - 1'b1;

	// one write port: append or shift-up
	always_comb begin
		we = 1'b0;
		wa = cnt_q[AW-1:0];
		wd = key;
		if (cmd.ins && !full) begin
			we = 1'b1;
		end else if (cmd.wr_shift && v_s1) begin
			we = 1'b1;
			wa = sh_dst[AW-1:0];
			wd = rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_s1 <= mem[idx_q[AW-1:0]];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.ins) begin
			rsp_q <= full ? make_rsp(ST_FULL, '0, '0)
			              : make_rsp(ST_OK, SLOT_W'(cnt_q), key);
		end else if (cmd.cap_hit) begin
			rsp_q <= make_rsp(ST_OK, SLOT_W'(idx_s1), rd_s1);
		end else if (cmd.miss) begin
			rsp_q <= make_rsp(ST_MISS, '0, '0);
		end
		idx_s1 <= idx_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			idx_q  <= '0;
			v_s1   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.fire;
			priority if (cmd.load) begin
				idx_q <= '0;
				v_s1  <= 1'b0;
			end else if (cmd.to_shift) begin
				idx_q <= idx_s1 + 1'b1;
				v_s1  <= 1'b0;
			end else if (cmd.step) begin
				v_s1 <= more;
				if (more) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (cmd.ins && !full) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.dec) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign sts.hit      = v_s1 && sntl_match(req_q.kind, rd_s1, key);
	assign sts.scan_end = !v_s1 && !more;
	assign sts.is_rem   = (req_q.kind == KIND_REMOVE);

	assign done = done_q;
	assign rsp  = rsp_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_shift && v_s1) |-> (idx_s1 != '0 && idx_s1 < cnt_q))
		else $error("shift write outside live rows");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ins && !full) |=> (cnt_q == CW'($past(cnt_q) + 1'b1)))
		else $error("append did not bump entry count");

endmodule

// ===== sv/sctp_nat_table_lookup.sv =====
// ----------------------------------------------------------------------------
// sctp_nat_table_lookup
// Ordered SCTP NAT table: append, first-hit lookups and remove with shift-up.
// ----------------------------------------------------------------------------
// Remove: the scan finds the hit row, then one row is moved per cycle through
//   the single memory port. Unknown kind: as a miss.
// Throughput: one request at a time; busy is high until the result cycle, and
//   start is taken again in the cycle that done is high.
// Reset: arst_n clears the entry count and the sequencer; table rows are not
//   cleared and are only used below the entry count. done is a one-cycle
//   strobe and cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module sctp_nat_table_lookup #(
	parameter int TABLE_DEPTH = sntl_pkg::TABLE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  sntl_pkg::req_t  req,
	output logic            busy,
	output logic            done,
	output sntl_pkg::rsp_t  rsp
);
	import sntl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: decides per cycle what the datapath does
	sntl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (req.kind),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// row memory, scan pipeline and result register
	sntl_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

	// every result transfer closes a request that was in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request in flight");

endmodule
